// ===== sv/clw_pkg.sv =====
// Shared types and constants for the CBOR item length walker.
`timescale 1ns / 1ps
`default_nettype none
package clw_pkg;

   localparam int MAX_NESTING_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] BREAK_BYTE = 8'hff;
   localparam logic [4:0] INFO_ARG1  = 5'd24;
   localparam logic [4:0] INFO_ARG8  = 5'd27;
   localparam logic [4:0] INFO_INDEF = 5'd31;

   localparam logic [2:0] MT_BYTES = 3'd2;
   localparam logic [2:0] MT_TEXT  = 3'd3;
   localparam logic [2:0] MT_ARRAY = 3'd4;
   localparam logic [2:0] MT_MAP   = 3'd5;

   // level flag bit positions
   localparam int FL_INDEF = 0;
   localparam int FL_MAP   = 1;

   typedef logic [63:0] word_type;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_ARG,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_RESERVED,
      ST_DEEP,
      ST_INDEFSTR,
      ST_BREAK
   } status_type;

   typedef enum logic [1:0] {
      EV_DONE,
      EV_PUSH,
      EV_BREAK,
      EV_ERR
   } ev_kind_type;

   // one structural event from the byte parser, with bytes since the last one
   typedef struct packed {
      ev_kind_type kind;
      status_type  status;
      logic [1:0]  flags;
      word_type    rem;
      word_type    delta;
   } ev_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DONE,
      BK_LOAD,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

// ===== sv/clw_front.sv =====
// Byte parser: head decode, argument collection, payload skip, event generation.
`timescale 1ns / 1ps
`default_nettype none
module clw_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic [7:0]      req_in_byte,
   input  logic            q_full,
   output logic            ev_push,
   output clw_pkg::ev_type ev_data
);
   import clw_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] hbl_ff, hbl_in;
   word_type   arg_ff, arg_in;
   logic [2:0] major_ff, major_in;
   word_type   pay_ff, pay_in;
   word_type   delta_ff, delta_in;

   logic       accept;
   word_type   delta_inc;
   word_type   arg_shift;
   logic [2:0] major;
   logic [4:0] info;
   logic       ev_go;
   logic       hd_go;
   logic [2:0] hd_major;
   word_type   hd_arg;

   always_comb begin
      accept    = req_push && !q_full;
      delta_inc = (&delta_ff) ? delta_ff : delta_ff + 64'd1;
      arg_shift = {arg_ff[55:0], req_in_byte};
      major     = req_in_byte[7:5];
      info      = req_in_byte[4:0];

      phase_in = phase_ff;
      hbl_in   = hbl_ff;
      arg_in   = arg_ff;
      major_in = major_ff;
      pay_in   = pay_ff;
      ev_go    = 1'b0;
      ev_data  = '{kind: EV_DONE, status: ST_OK, flags: 2'b00, rem: '0, delta: delta_inc};
      hd_go    = 1'b0;
      hd_major = major;
      hd_arg   = {59'd0, info};

      unique case (phase_ff)
         PH_SKIP: begin
            if (pay_ff <= 64'd1) begin
               phase_in = PH_HEAD;
               pay_in   = '0;
               ev_go    = 1'b1;
            end else begin
               pay_in = pay_ff - 64'd1;
            end
         end
         PH_ARG: begin
            arg_in = arg_shift;
            if (hbl_ff <= 4'd1) begin
               hbl_in   = '0;
               phase_in = PH_HEAD;
               hd_go    = 1'b1;
               hd_major = major_ff;
               hd_arg   = arg_shift;
            end else begin
               hbl_in = hbl_ff - 4'd1;
            end
         end
         default: begin
            phase_in = PH_HEAD;
            if (req_in_byte == BREAK_BYTE) begin
               ev_go        = 1'b1;
               ev_data.kind = EV_BREAK;
            end else if (info < INFO_ARG1) begin
               hd_go = 1'b1;
            end else if (info <= INFO_ARG8) begin
               major_in = major;
               arg_in   = '0;
               hbl_in   = 4'd1 << info[1:0];
               phase_in = PH_ARG;
            end else if (info != INFO_INDEF) begin
               ev_go          = 1'b1;
               ev_data.kind   = EV_ERR;
               ev_data.status = ST_RESERVED;
            end else begin
               ev_go = 1'b1;
               unique case (major) inside
                  MT_BYTES, MT_TEXT: begin
                     ev_data.kind   = EV_ERR;
                     ev_data.status = ST_INDEFSTR;
                  end
                  MT_ARRAY: begin
                     ev_data.kind            = EV_PUSH;
                     ev_data.flags[FL_INDEF] = 1'b1;
                  end
                  MT_MAP: begin
                     ev_data.kind            = EV_PUSH;
                     ev_data.flags[FL_INDEF] = 1'b1;
                     ev_data.flags[FL_MAP]   = 1'b1;
                  end
                  default: begin
                     ev_data.kind   = EV_ERR;
                     ev_data.status = ST_RESERVED;
                  end
               endcase
            end
         end
      endcase

      if (hd_go) begin
         unique case (hd_major) inside
            MT_BYTES, MT_TEXT: begin
               if (hd_arg == '0) begin
                  ev_go = 1'b1;
               end else begin
                  pay_in   = hd_arg;
                  phase_in = PH_SKIP;
               end
            end
            MT_ARRAY: begin
               ev_go = 1'b1;
               if (hd_arg != '0) begin
                  ev_data.kind = EV_PUSH;
                  ev_data.rem  = hd_arg;
               end
            end
            MT_MAP: begin
               ev_go = 1'b1;
               if (hd_arg != '0) begin
                  ev_data.kind          = EV_PUSH;
                  ev_data.flags[FL_MAP] = 1'b1;
                  ev_data.rem           = hd_arg[63] ? '1 : {hd_arg[62:0], 1'b0};
               end
            end
            default: begin
               ev_go = 1'b1;
            end
         endcase
      end

      delta_in = ev_go ? '0 : delta_inc;
      ev_push  = accept && ev_go;
      req_full = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         hbl_ff   <= '0;
         delta_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hbl_ff   <= hbl_in;
         delta_ff <= delta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         arg_ff   <= arg_in;
         major_ff <= major_in;
         pay_ff   <= pay_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/clw_queue.sv =====
// Short event queue between the byte parser and the nesting tracker.
`timescale 1ns / 1ps
`default_nettype none
module clw_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  clw_pkg::ev_type din,
   input  logic            pop,
   output logic            empty,
   output clw_pkg::ev_type dout
);
   import clw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   ev_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push_ok;
   logic             pop_ok;

   always_comb begin
      full      = cnt_ff == CNT_W'(QUEUE_DEPTH);
      empty     = cnt_ff == '0;
      dout      = slot_ff[rd_ptr_ff];
      push_ok   = push && !full;
      pop_ok    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

// ===== sv/clw_back.sv =====
// Nesting tracker: container stack, item completion cascade, result register.
`timescale 1ns / 1ps
`default_nettype none
module clw_back #(
   parameter int MAX_NESTING = clw_pkg::MAX_NESTING_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  clw_pkg::ev_type q_dout,
   output logic            q_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [63:0]     rsp_item_bytes,
   output logic [2:0]      rsp_status
);
   import clw_pkg::*;

   localparam int LVL_W = $clog2(MAX_NESTING + 1);
   localparam int IDX_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

   back_state_type   state_ff, state_in;
   ev_type           ev_ff, ev_in;
   word_type         acc_ff, acc_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   word_type         top_rem_ff, top_rem_in;
   logic [1:0]       top_flags_ff, top_flags_in;
   status_type       st_ff, st_in;
   logic             out_valid_ff, out_valid_in;
   word_type         out_bytes_ff, out_bytes_in;
   status_type       out_status_ff, out_status_in;

   // levels below the top one; the top level lives in top_rem_ff/top_flags_ff
   word_type         rem_mem [MAX_NESTING];
   logic [1:0]       flag_mem [MAX_NESTING];
   word_type         rd_rem_ff;
   logic [1:0]       rd_flags_ff;

   logic [64:0]      sum;
   word_type         acc_add;
   logic [LVL_W-1:0] lvl_m1;
   logic [LVL_W-1:0] lvl_m2;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             last_lvl;
   logic             mem_we;
   logic             out_free;

   always_comb begin
      sum      = {1'b0, acc_ff} + {1'b0, q_dout.delta};
      acc_add  = sum[64] ? '1 : sum[63:0];
      lvl_m1   = lvl_ff - LVL_W'(1);
      lvl_m2   = lvl_ff - LVL_W'(2);
      wr_idx   = lvl_m1[IDX_W-1:0];
      rd_idx   = lvl_m2[IDX_W-1:0];
      last_lvl = lvl_ff == LVL_W'(1);
      out_free = !out_valid_ff || rsp_pop;

      state_in      = state_ff;
      ev_in         = ev_ff;
      acc_in        = acc_ff;
      lvl_in        = lvl_ff;
      top_rem_in    = top_rem_ff;
      top_flags_in  = top_flags_ff;
      st_in         = st_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_bytes_in  = out_bytes_ff;
      out_status_in = out_status_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ev_in    = q_dout;
               acc_in   = acc_add;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            unique case (ev_ff.kind)
               EV_ERR: begin
                  st_in    = ev_ff.status;
                  state_in = BK_EMIT;
               end
               EV_PUSH: begin
                  if (lvl_ff >= LVL_W'(MAX_NESTING)) begin
                     st_in    = ST_DEEP;
                     state_in = BK_EMIT;
                  end else begin
                     mem_we       = lvl_ff != '0;
                     top_rem_in   = ev_ff.rem;
                     top_flags_in = ev_ff.flags;
                     lvl_in       = lvl_ff + LVL_W'(1);
                     state_in     = BK_IDLE;
                  end
               end
               EV_BREAK: begin
                  if (lvl_ff != '0 && top_flags_ff[FL_INDEF] &&
                      (!top_flags_ff[FL_MAP] || !top_rem_ff[0])) begin
                     lvl_in = lvl_m1;
                     if (last_lvl) begin
                        st_in    = ST_OK;
                        state_in = BK_EMIT;
                     end else begin
                        state_in = BK_LOAD;
                     end
                  end else begin
                     st_in    = ST_BREAK;
                     state_in = BK_EMIT;
                  end
               end
               default: begin
                  state_in = BK_DONE;
               end
            endcase
         end
         BK_DONE: begin
            if (lvl_ff == '0) begin
               st_in    = ST_OK;
               state_in = BK_EMIT;
            end else if (top_flags_ff[FL_INDEF]) begin
               top_rem_in = top_rem_ff + 64'd1;
               state_in   = BK_IDLE;
            end else if (top_rem_ff > 64'd1) begin
               top_rem_in = top_rem_ff - 64'd1;
               state_in   = BK_IDLE;
            end else begin
               lvl_in = lvl_m1;
               if (last_lvl) begin
                  st_in    = ST_OK;
                  state_in = BK_EMIT;
               end else begin
                  state_in = BK_LOAD;
               end
            end
         end
         BK_LOAD: begin
            top_rem_in   = rd_rem_ff;
            top_flags_in = rd_flags_ff;
            state_in     = BK_DONE;
         end
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_bytes_in  = acc_ff;
               out_status_in = st_ff;
               acc_in        = '0;
               lvl_in        = '0;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         acc_ff       <= '0;
         lvl_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         lvl_ff       <= lvl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff         <= ev_in;
      top_rem_ff    <= top_rem_in;
      top_flags_ff  <= top_flags_in;
      st_ff         <= st_in;
      out_bytes_ff  <= out_bytes_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rem_mem[wr_idx]  <= top_rem_ff;
         flag_mem[wr_idx] <= top_flags_ff;
      end
      rd_rem_ff   <= rem_mem[rd_idx];
      rd_flags_ff <= flag_mem[rd_idx];
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_item_bytes = out_bytes_ff;
   assign rsp_status     = out_status_ff;

endmodule
`default_nettype wire

// ===== sv/cbor_item_length_walker_top.sv =====
// Top level of the CBOR item length walker.
//
// Usage: CBOR bytes enter on the req_ queue port, one byte per transfer
// (req_push while req_full is low). For every completed top-level data item,
// or on a decoding error, one result is offered on the rsp_ queue port:
// rsp_item_bytes is the saturating byte count of the item, rsp_status the code
// (ok, reserved info, too deep, indefinite string, stray break). The result
// stays until taken with rsp_pop while rsp_empty is low.
// Flow: the byte parser takes one byte per cycle while the event queue is not
// full. Bytes that open, close or complete something become events in a
// two-entry queue; the nesting tracker pops an event in BK_IDLE, handles it in
// BK_EXEC and goes back to idle after an open, to BK_DONE after a completion
// and to BK_EMIT after an error or a break that closes the item; each level
// closed while an outer one stays open passes through BK_LOAD and BK_DONE, and
// BK_EMIT loads the result register. A new event is taken only in BK_IDLE, so
// the rate is one byte per cycle through payload and argument bytes, while on a
// run of one-byte items it is set by the tracker's event handling.
// Reset clears the stack, the counts and the queues; rsp_empty goes high.
// When the receiver stalls, the tracker holds its result and the event queue
// fills; req_full then rises until results are taken.
`timescale 1ns / 1ps
`default_nettype none
module cbor_item_length_walker_top #(
   parameter int MAX_NESTING = clw_pkg::MAX_NESTING_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_item_bytes,
   output logic [2:0]  rsp_status
);
   import clw_pkg::*;

   logic   ev_push;
   ev_type ev_din;
   logic   q_full;
   logic   q_empty;
   logic   q_pop;
   ev_type q_dout;

   clw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .ev_push     (ev_push),
      .ev_data     (ev_din)
   );

   clw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (ev_push),
      .full  (q_full),
      .din   (ev_din),
      .pop   (q_pop),
      .empty (q_empty),
      .dout  (q_dout)
   );

   clw_back #(
      .MAX_NESTING (MAX_NESTING)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_dout         (q_dout),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_item_bytes (rsp_item_bytes),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

// ===== sv/clw_checker.sv =====
// Port-level checks for the CBOR item length walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module clw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [63:0] rsp_item_bytes,
   input logic [2:0]  rsp_status
);

   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_status_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status <= 3'd4)
      else $error("result status out of range");

   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_item_bytes != 64'd0)
      else $error("result with zero byte count");

   a_result_hold : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=>
         !rsp_empty && $stable(rsp_item_bytes) && $stable(rsp_status))
      else $error("waiting result changed");

endmodule

bind cbor_item_length_walker_top clw_checker u_clw_checker (.*);
`default_nettype wire
